// File: rtl/h2r_pkg.sv
// Shared constants and types for the HSV to RGB converter.
`timescale 1ns / 1ps
package h2r_pkg;

    localparam int HueW  = 16;
    localparam int ChanW = 8;
    localparam int TickW = 11;

    localparam logic [TickW-1:0] RAMP       = 11'd255;
    localparam logic [TickW-1:0] TICKS_FULL = 11'd1530;
    localparam logic [TickW-1:0] HUE_MUL    = 11'd1530;
    localparam logic [HueW+TickW-1:0] HUE_ROUND = 27'd32768;

    typedef struct packed {
        logic [ChanW-1:0] red;
        logic [ChanW-1:0] green;
        logic [ChanW-1:0] blue;
    } t_rgb8;

endpackage

// File: rtl/hsv_to_rgb_888.sv
// Top level of the HSV to RGB converter, 8 bits per channel.
//
// Input channel: i_valid / o_ready with i_hue (16 bits, full circle),
// i_saturation and i_brightness (8 bits each). Output channel:
// o_valid / i_ready with o_red, o_green and o_blue (8 bits each).
// An item moves on a rising edge where its valid and ready are high.
// Every input item gives exactly one output item, in order.
// From input acceptance to output valid, an item passes the registered stages
// hue scaling, segment decode, saturation scaling and brightness scaling.
// Throughput is one item per cycle while i_ready is high; each stage holds its own valid bit.
// When the receiver drops i_ready, the output register holds its item
// and bubbles in the pipe are filled first; o_ready falls only once
// every stage is occupied, so no item is lost or repeated.
// Synchronous active-low reset clears all valid bits; the pipe is empty
// and ready for input as soon as reset is released.
`timescale 1ns / 1ps
module hsv_to_rgb_888
    import h2r_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [HueW-1:0]  i_hue,
    input  logic [ChanW-1:0] i_saturation,
    input  logic [ChanW-1:0] i_brightness,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [ChanW-1:0] o_red,
    output logic [ChanW-1:0] o_green,
    output logic [ChanW-1:0] o_blue
);

    logic             w_mid_valid;
    logic             w_mid_ready;
    t_rgb8            w_mid_rgb;
    logic [ChanW-1:0] w_mid_sat;
    logic [ChanW-1:0] w_mid_val;
    t_rgb8            w_out_rgb;

    h2r_hue_seg u_hue_seg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_hue   (i_hue),
        .i_sat   (i_saturation),
        .i_val   (i_brightness),
        .o_valid (w_mid_valid),
        .i_ready (w_mid_ready),
        .o_rgb   (w_mid_rgb),
        .o_sat   (w_mid_sat),
        .o_val   (w_mid_val)
    );

    h2r_sat_val u_sat_val (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_mid_valid),
        .o_ready (w_mid_ready),
        .i_rgb   (w_mid_rgb),
        .i_sat   (w_mid_sat),
        .i_val   (w_mid_val),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_rgb   (w_out_rgb)
    );

    assign o_red   = w_out_rgb.red;
    assign o_green = w_out_rgb.green;
    assign o_blue  = w_out_rgb.blue;

endmodule

// File: rtl/h2r_hue_seg.sv
// Hue scaling to the tick circle and segment decode to a full-saturation color.
`timescale 1ns / 1ps
module h2r_hue_seg
    import h2r_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [HueW-1:0]  i_hue,
    input  logic [ChanW-1:0] i_sat,
    input  logic [ChanW-1:0] i_val,
    output logic             o_valid,
    input  logic             i_ready,
    output t_rgb8            o_rgb,
    output logic [ChanW-1:0] o_sat,
    output logic [ChanW-1:0] o_val
);

    logic                  r_v1;
    logic [TickW-1:0]      r_t1;
    logic [ChanW-1:0]      r_s1;
    logic [ChanW-1:0]      r_b1;
    logic                  r_v2;
    t_rgb8                 r_rgb2;
    logic [ChanW-1:0]      r_s2;
    logic [ChanW-1:0]      r_b2;

    logic                  w_adv1;
    logic                  w_adv2;
    logic [HueW+TickW-1:0] w_prod;
    logic [HueW+TickW-1:0] w_sum;
    logic [TickW-1:0]      n_t1;
    t_rgb8                 n_rgb2;
    logic [TickW-1:0]      w_dn;

    assign w_adv2  = !r_v2 || i_ready;
    assign w_adv1  = !r_v1 || w_adv2;
    assign o_ready = w_adv1;

    assign w_prod = (HueW+TickW)'(i_hue) * (HueW+TickW)'(HUE_MUL);
    assign w_sum  = w_prod + HUE_ROUND;
    assign n_t1   = w_sum[HueW+TickW-1:HueW];

    always_comb begin
        n_rgb2 = '0;
        w_dn   = '0;
        if (r_t1 < RAMP) begin
            n_rgb2.red   = 8'd255;
            n_rgb2.green = r_t1[ChanW-1:0];
        end else if (r_t1 < 11'd510) begin
            w_dn         = 11'd510 - r_t1;
            n_rgb2.red   = w_dn[ChanW-1:0];
            n_rgb2.green = 8'd255;
        end else if (r_t1 < 11'd765) begin
            w_dn         = r_t1 - 11'd510;
            n_rgb2.green = 8'd255;
            n_rgb2.blue  = w_dn[ChanW-1:0];
        end else if (r_t1 < 11'd1020) begin
            w_dn         = 11'd1020 - r_t1;
            n_rgb2.green = w_dn[ChanW-1:0];
            n_rgb2.blue  = 8'd255;
        end else if (r_t1 < 11'd1275) begin
            w_dn         = r_t1 - 11'd1020;
            n_rgb2.red   = w_dn[ChanW-1:0];
            n_rgb2.blue  = 8'd255;
        end else if (r_t1 < TICKS_FULL) begin
            w_dn         = TICKS_FULL - r_t1;
            n_rgb2.red   = 8'd255;
            n_rgb2.blue  = w_dn[ChanW-1:0];
        end else begin
            n_rgb2.red   = 8'd255;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_adv1) begin
                r_v1 <= i_valid;
            end
            if (w_adv2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv1 && i_valid) begin
            r_t1 <= n_t1;
            r_s1 <= i_sat;
            r_b1 <= i_val;
        end
        if (w_adv2 && r_v1) begin
            r_rgb2 <= n_rgb2;
            r_s2   <= r_s1;
            r_b2   <= r_b1;
        end
    end

    assign o_valid = r_v2;
    assign o_rgb   = r_rgb2;
    assign o_sat   = r_s2;
    assign o_val   = r_b2;

endmodule

// File: rtl/h2r_sat_val.sv
// Saturation and brightness scaling of the three channels.
`timescale 1ns / 1ps
module h2r_sat_val
    import h2r_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  t_rgb8            i_rgb,
    input  logic [ChanW-1:0] i_sat,
    input  logic [ChanW-1:0] i_val,
    output logic             o_valid,
    input  logic             i_ready,
    output t_rgb8            o_rgb
);

    logic               r_v3;
    logic [ChanW:0]     r_xr;
    logic [ChanW:0]     r_xg;
    logic [ChanW:0]     r_xb;
    logic [ChanW:0]     r_vp1;
    logic               r_v4;
    t_rgb8              r_rgb4;

    logic               w_adv3;
    logic               w_adv4;
    logic [ChanW:0]     w_sp1;
    logic [ChanW:0]     w_ns;
    logic [2*ChanW:0]   w_pr;
    logic [2*ChanW:0]   w_pg;
    logic [2*ChanW:0]   w_pb;
    logic [ChanW:0]     n_xr;
    logic [ChanW:0]     n_xg;
    logic [ChanW:0]     n_xb;
    logic [2*ChanW+1:0] w_qr;
    logic [2*ChanW+1:0] w_qg;
    logic [2*ChanW+1:0] w_qb;
    t_rgb8              n_rgb4;

    assign w_adv4  = !r_v4 || i_ready;
    assign w_adv3  = !r_v3 || w_adv4;
    assign o_ready = w_adv3;

    assign w_sp1 = (ChanW+1)'(i_sat) + (ChanW+1)'(1);
    assign w_ns  = (ChanW+1)'(8'd255 - i_sat);
    assign w_pr  = (2*ChanW+1)'(i_rgb.red)   * (2*ChanW+1)'(w_sp1);
    assign w_pg  = (2*ChanW+1)'(i_rgb.green) * (2*ChanW+1)'(w_sp1);
    assign w_pb  = (2*ChanW+1)'(i_rgb.blue)  * (2*ChanW+1)'(w_sp1);
    assign n_xr  = (ChanW+1)'(w_pr[2*ChanW:ChanW]) + w_ns;
    assign n_xg  = (ChanW+1)'(w_pg[2*ChanW:ChanW]) + w_ns;
    assign n_xb  = (ChanW+1)'(w_pb[2*ChanW:ChanW]) + w_ns;

    assign w_qr = (2*ChanW+2)'(r_xr) * (2*ChanW+2)'(r_vp1);
    assign w_qg = (2*ChanW+2)'(r_xg) * (2*ChanW+2)'(r_vp1);
    assign w_qb = (2*ChanW+2)'(r_xb) * (2*ChanW+2)'(r_vp1);
    assign n_rgb4.red   = w_qr[2*ChanW-1:ChanW];
    assign n_rgb4.green = w_qg[2*ChanW-1:ChanW];
    assign n_rgb4.blue  = w_qb[2*ChanW-1:ChanW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_adv3) begin
                r_v3 <= i_valid;
            end
            if (w_adv4) begin
                r_v4 <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv3 && i_valid) begin
            r_xr  <= n_xr;
            r_xg  <= n_xg;
            r_xb  <= n_xb;
            r_vp1 <= (ChanW+1)'(i_val) + (ChanW+1)'(1);
        end
        if (w_adv4 && r_v3) begin
            r_rgb4 <= n_rgb4;
        end
    end

    assign o_valid = r_v4;
    assign o_rgb   = r_rgb4;

endmodule

// File: tb/hsv_to_rgb_888_tb.sv
// Self-checking testbench for the HSV to RGB 888 converter pipeline.
`timescale 1ns / 1ps
module hsv_to_rgb_888_tb
    import h2r_pkg::*;
();

    localparam int NumCorners  = 24;
    localparam int RandomItems = 480;
    localparam int IdleLimit   = 2000;

    typedef struct packed {
        logic [HueW-1:0]  hue;
        logic [ChanW-1:0] sat;
        logic [ChanW-1:0] val;
        logic             typed;
        t_rgb8            rgb;
    } t_corner_row;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_valid = 1'b0;
    logic             o_ready;
    logic [HueW-1:0]  i_hue = '0;
    logic [ChanW-1:0] i_saturation = '0;
    logic [ChanW-1:0] i_brightness = '0;
    logic             o_valid;
    logic             i_ready = 1'b0;
    logic [ChanW-1:0] o_red;
    logic [ChanW-1:0] o_green;
    logic [ChanW-1:0] o_blue;

    t_rgb8 rgb_pending[$];
    int    mismatches = 0;
    int    colors_sent = 0;
    int    colors_checked = 0;
    int    stall_pct = 22;
    int    gap_pct = 22;
    int    stuck_cycles = 0;

    t_corner_row corner_rows [0:NumCorners-1] = '{
        '{16'h0000, 8'd255, 8'd255, 1'b1, 24'hFF0000},
        '{16'hFFFF, 8'd255, 8'd255, 1'b1, 24'hFF0000},
        '{16'h5555, 8'd255, 8'd255, 1'b1, 24'h00FF00},
        '{16'hAAAA, 8'd255, 8'd255, 1'b1, 24'h0000FF},
        '{16'h1234, 8'd0,   8'd255, 1'b1, 24'hFFFFFF},
        '{16'h8000, 8'd0,   8'd128, 1'b1, 24'h808080},
        '{16'hC000, 8'd255, 8'd0,   1'b1, 24'h000000},
        '{16'hFFFF, 8'd0,   8'd0,   1'b1, 24'h000000},
        '{16'h0000, 8'd0,   8'd0,   1'b1, 24'h000000},
        '{16'h2AA9, 8'd255, 8'd255, 1'b0, 24'h000000},
        '{16'h2AAB, 8'd255, 8'd255, 1'b0, 24'h000000},
        '{16'h5550, 8'd200, 8'd255, 1'b0, 24'h000000},
        '{16'h7FF8, 8'd255, 8'd200, 1'b0, 24'h000000},
        '{16'h8008, 8'd1,   8'd254, 1'b0, 24'h000000},
        '{16'hAAA0, 8'd254, 8'd1,   1'b0, 24'h000000},
        '{16'hD550, 8'd255, 8'd255, 1'b0, 24'h000000},
        '{16'hD560, 8'd128, 8'd64,  1'b0, 24'h000000},
        '{16'hFFEA, 8'd255, 8'd255, 1'b0, 24'h000000},
        '{16'hFFEB, 8'd255, 8'd255, 1'b0, 24'h000000},
        '{16'hFFEB, 8'd77,  8'd190, 1'b0, 24'h000000},
        '{16'h0001, 8'd254, 8'd254, 1'b0, 24'h000000},
        '{16'h3FFF, 8'd1,   8'd1,   1'b0, 24'h000000},
        '{16'hA5A5, 8'd170, 8'd85,  1'b0, 24'h000000},
        '{16'h5A5A, 8'd85,  8'd170, 1'b0, 24'h000000}
    };

    hsv_to_rgb_888 dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_hue        (i_hue),
        .i_saturation (i_saturation),
        .i_brightness (i_brightness),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_red        (o_red),
        .o_green      (o_green),
        .o_blue       (o_blue)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic logic [ChanW-1:0] shade_level(input logic [TickW-1:0] level,
                                                     input logic [ChanW-1:0] sat,
                                                     input logic [ChanW-1:0] val);
        logic [16:0] acc;
        acc = (level * (sat + 17'd1)) >> 8;
        acc = acc + 17'd255 - sat;
        acc = (acc * (val + 17'd1)) >> 8;
        return acc[ChanW-1:0];
    endfunction

    function automatic t_rgb8 rgb_from_hsv(input logic [HueW-1:0] hue,
                                           input logic [ChanW-1:0] sat,
                                           input logic [ChanW-1:0] val);
        logic [HueW+TickW-1:0] scaled;
        logic [TickW-1:0]      tick;
        logic [TickW-1:0]      r;
        logic [TickW-1:0]      g;
        logic [TickW-1:0]      b;
        t_rgb8                 rgb;
        scaled = hue * 27'd1530 + 27'd32768;
        tick   = scaled[HueW+TickW-1:HueW];
        if (tick < 11'd255) begin
            r = 11'd255; g = tick; b = 11'd0;
        end else if (tick < 11'd510) begin
            r = 11'd510 - tick; g = 11'd255; b = 11'd0;
        end else if (tick < 11'd765) begin
            r = 11'd0; g = 11'd255; b = tick - 11'd510;
        end else if (tick < 11'd1020) begin
            r = 11'd0; g = 11'd1020 - tick; b = 11'd255;
        end else if (tick < 11'd1275) begin
            r = tick - 11'd1020; g = 11'd0; b = 11'd255;
        end else if (tick < 11'd1530) begin
            r = 11'd255; g = 11'd0; b = 11'd1530 - tick;
        end else begin
            r = 11'd255; g = 11'd0; b = 11'd0;
        end
        rgb.red   = shade_level(r, sat, val);
        rgb.green = shade_level(g, sat, val);
        rgb.blue  = shade_level(b, sat, val);
        return rgb;
    endfunction

    function automatic logic [ChanW-1:0] extreme_level();
        case ($urandom_range(3))
            0: return 8'd0;
            1: return 8'd1;
            2: return 8'd254;
            default: return 8'd255;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH on result %0d: %s got %0d, expected %0d",
                 colors_checked, what, got, want);
        mismatches++;
    endtask

    task automatic send_color(input logic [HueW-1:0] hue, input logic [ChanW-1:0] sat,
                              input logic [ChanW-1:0] val, input logic typed,
                              input t_rgb8 typed_rgb);
        while ($urandom_range(99) < gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_hue        <= hue;
        i_saturation <= sat;
        i_brightness <= val;
        do @(posedge i_clk); while (!o_ready);
        rgb_pending.push_back(typed ? typed_rgb : rgb_from_hsv(hue, sat, val));
        colors_sent++;
    endtask

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        t_rgb8 want;
        if (i_rst_n && o_valid && i_ready) begin
            if (rgb_pending.size() == 0) begin
                report_mismatch("red with no item pending", int'(o_red), 0);
            end else begin
                want = rgb_pending.pop_front();
                if (o_red !== want.red)
                    report_mismatch("red", int'(o_red), int'(want.red));
                if (o_green !== want.green)
                    report_mismatch("green", int'(o_green), int'(want.green));
                if (o_blue !== want.blue)
                    report_mismatch("blue", int'(o_blue), int'(want.blue));
            end
            colors_checked++;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles < IdleLimit) begin
            stuck_cycles <= stuck_cycles + 1;
        end else begin
            $display("Timeout: no item moved for %0d cycles", IdleLimit);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        logic [HueW-1:0]  hue;
        logic [ChanW-1:0] sat;
        logic [ChanW-1:0] val;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int k = 0; k < NumCorners; k++) begin
            send_color(corner_rows[k].hue, corner_rows[k].sat, corner_rows[k].val,
                       corner_rows[k].typed, corner_rows[k].rgb);
        end
        for (int n = 0; n < RandomItems; n++) begin
            if (n == 150) begin
                stall_pct = 0;
                gap_pct   = 0;
            end
            if (n == 300) begin
                stall_pct = 22;
                gap_pct   = 22;
                i_valid  <= 1'b0;
                do @(posedge i_clk); while (rgb_pending.size() != 0);
            end
            hue = HueW'($urandom_range(16'hFFFF));
            sat = ChanW'($urandom_range(8'hFF));
            val = ChanW'($urandom_range(8'hFF));
            if ($urandom_range(9) < 3) begin
                hue = HueW'($urandom_range(6) * 65536 / 6 + $urandom_range(64) - 32);
                sat = extreme_level();
                val = extreme_level();
            end
            send_color(hue, sat, val, 1'b0, '0);
        end
        i_valid <= 1'b0;
        do @(posedge i_clk); while (rgb_pending.size() != 0);
        repeat (8) @(posedge i_clk);
        $display("Sent %0d colors: %0d corner rows, the rest random with segment edges",
                 colors_sent, NumCorners);
        $display("Checked %0d results under random stalls, a no-stall run and a full drain",
                 colors_checked);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/h2r_pkg.sv
rtl/h2r_hue_seg.sv
rtl/h2r_sat_val.sv
rtl/hsv_to_rgb_888.sv
tb/hsv_to_rgb_888_tb.sv
